>>> rtl/ascii_record_frame_parser_macros.svh
// Assertion macros used by the checker file.
`ifndef ASCII_RECORD_FRAME_PARSER_MACROS_SVH
`define ASCII_RECORD_FRAME_PARSER_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ARFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ARFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/arfp_pkg.sv
package arfp_pkg;

    // Character codes recognized by the parser.
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_TAG  = 8'h40;
    localparam logic [7:0] CH_END  = 8'h24;

    // Command passed from the byte classifier to the payload engine.
    typedef struct packed {
        logic       is_end;
        logic       qty_ok;
        logic [2:0] quantity;
        logic [7:0] data;
    } t_cmd;

    // One decoded result.
    typedef struct packed {
        logic [2:0]  quantity;
        logic [15:0] value;
    } t_result;

endpackage

>>> rtl/arfp_fifo.sv
module arfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/arfp_front.sv
module arfp_front import arfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    input  logic       i_response_busy,
    input  logic       i_cmd_full,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    // Row tag phases.
    localparam logic [1:0] TAG_IDLE  = 2'd0;
    localparam logic [1:0] TAG_TENS  = 2'd1;
    localparam logic [1:0] TAG_UNITS = 2'd2;

    // Rows that carry a reading, and their quantity codes.
    localparam logic [7:0] ROW_WIRE_SPEED  = 8'd10;
    localparam logic [7:0] ROW_SET_CURRENT = 8'd11;
    localparam logic [7:0] ROW_SET_VOLTAGE = 8'd12;
    localparam logic [7:0] ROW_ACT_CURRENT = 8'd21;
    localparam logic [7:0] ROW_ACT_VOLTAGE = 8'd22;
    localparam logic [2:0] QTY_WIRE_SPEED  = 3'd0;
    localparam logic [2:0] QTY_SET_CURRENT = 3'd1;
    localparam logic [2:0] QTY_SET_VOLTAGE = 3'd2;
    localparam logic [2:0] QTY_ACT_CURRENT = 3'd3;
    localparam logic [2:0] QTY_ACT_VOLTAGE = 3'd4;

    logic [1:0] r_cr_count, n_cr_count;
    logic       r_open, n_open;
    logic [1:0] r_tag, n_tag;
    logic       r_known, n_known;
    logic [7:0] r_tens, n_tens;
    logic [7:0] r_row, n_row;
    logic       accept;
    logic [7:0] tens_d, unit_d, row_calc;
    logic       qty_ok;
    logic [2:0] qty;

    assign accept = i_push && !i_cmd_full;

    // Row number from the two tag digits, wrapped to eight bits.
    assign tens_d   = r_tens - CH_ZERO;
    assign unit_d   = i_rx_byte - CH_ZERO;
    assign row_calc = (tens_d << 3) + (tens_d << 1) + unit_d;

    // Row to quantity lookup.
    always_comb begin
        qty_ok = 1'b1;
        qty    = QTY_WIRE_SPEED;
        unique case (r_row)
            ROW_WIRE_SPEED:  qty = QTY_WIRE_SPEED;
            ROW_SET_CURRENT: qty = QTY_SET_CURRENT;
            ROW_SET_VOLTAGE: qty = QTY_SET_VOLTAGE;
            ROW_ACT_CURRENT: qty = QTY_ACT_CURRENT;
            ROW_ACT_VOLTAGE: qty = QTY_ACT_VOLTAGE;
            default:         qty_ok = 1'b0;
        endcase
    end

    // Byte classification; the first rule that matches wins.
    always_comb begin
        n_cr_count     = r_cr_count;
        n_open         = r_open;
        n_tag          = r_tag;
        n_known        = r_known;
        n_tens         = r_tens;
        n_row          = r_row;
        o_cmd_push     = 1'b0;
        o_cmd.is_end   = 1'b0;
        o_cmd.qty_ok   = 1'b0;
        o_cmd.quantity = qty;
        o_cmd.data     = i_rx_byte;
        if (accept) begin
            if (i_rx_byte == CH_CR && r_cr_count < 2'd2 && !i_response_busy) begin
                n_cr_count = r_cr_count + 1'b1;
            end else if (i_rx_byte == CH_LF && (r_cr_count == 2'd1 || r_cr_count == 2'd2)
                         && !r_open) begin
                n_cr_count = '0;
                n_open     = 1'b1;
            end else if (r_open && i_rx_byte != CH_CR && i_rx_byte != CH_LF) begin
                if (i_rx_byte == CH_TAG) begin
                    n_tag = TAG_TENS;
                end else if (r_tag == TAG_TENS) begin
                    n_tag   = TAG_UNITS;
                    n_known = 1'b0;
                    n_tens  = i_rx_byte;
                end else if (r_tag == TAG_UNITS && !r_known) begin
                    n_tag   = TAG_IDLE;
                    n_known = 1'b1;
                    n_row   = row_calc;
                end else if (r_known) begin
                    o_cmd_push = 1'b1;
                    if (i_rx_byte == CH_END) begin
                        o_cmd.is_end = 1'b1;
                        o_cmd.qty_ok = qty_ok;
                        n_known      = 1'b0;
                        n_open       = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_count <= '0;
            r_open     <= 1'b0;
            r_tag      <= TAG_IDLE;
            r_known    <= 1'b0;
        end else begin
            r_cr_count <= n_cr_count;
            r_open     <= n_open;
            r_tag      <= n_tag;
            r_known    <= n_known;
        end
    end

    // Tag bytes are only read after the phase that loads them.
    always_ff @(posedge i_clk) begin
        r_tens <= n_tens;
        r_row  <= n_row;
    end

endmodule

>>> rtl/arfp_back.sv
module arfp_back import arfp_pkg::*; #(
    parameter int PAYLOAD_DEPTH = 8,
    parameter int PAYLOAD_START = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int AW  = $clog2(PAYLOAD_DEPTH);
    localparam int WSW = $clog2(PAYLOAD_DEPTH + 1);
    localparam int SLW = $clog2(PAYLOAD_DEPTH + 5);
    localparam logic [2:0] DIGITS = 3'd4;

    // Engine states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEC  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [7:0]         r_mem [PAYLOAD_DEPTH];
    logic [PAYLOAD_DEPTH-1:0] r_valid;
    logic [1:0]         r_state, n_state;
    logic [WSW-1:0]     r_wslot, n_wslot;
    logic [2:0]         r_k, n_k;
    logic [15:0]        r_acc, n_acc;
    logic [2:0]         r_qty, n_qty;
    logic [7:0]         r_rd_data;
    logic               r_rd_ok;
    logic [SLW-1:0]     slot;
    logic               slot_in_range;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [15:0]        digit;
    logic [15:0]        acc_step;

    // Decode read address; slots past the store read as zero.
    assign slot          = SLW'(PAYLOAD_START) + SLW'(r_k);
    assign slot_in_range = slot < SLW'(PAYLOAD_DEPTH);
    assign rd_addr       = slot[AW-1:0];
    assign wr_addr       = r_wslot[AW-1:0];

    assign o_cmd_pop = (r_state == ST_IDLE) && !i_cmd_empty;
    assign wr_en     = o_cmd_pop && !i_cmd.is_end && (r_wslot < WSW'(PAYLOAD_DEPTH));

    // One decimal digit per cycle: acc * 10 + digit, wrapped to 16 bits.
    assign digit    = (r_rd_ok ? {8'h00, r_rd_data} : 16'h0000) - {8'h00, CH_ZERO};
    assign acc_step = (r_acc << 3) + (r_acc << 1) + digit;

    assign o_res_push     = (r_state == ST_OUT) && !i_res_full;
    assign o_res.quantity = r_qty;
    assign o_res.value    = r_acc;

    // Command sequencer.
    always_comb begin
        n_state = r_state;
        n_wslot = r_wslot;
        n_k     = r_k;
        n_acc   = r_acc;
        n_qty   = r_qty;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    if (i_cmd.is_end) begin
                        n_wslot = '0;
                        if (i_cmd.qty_ok) begin
                            n_state = ST_DEC;
                            n_k     = '0;
                            n_acc   = '0;
                            n_qty   = i_cmd.quantity;
                        end
                    end else if (wr_en) begin
                        n_wslot = r_wslot + 1'b1;
                    end
                end
            end
            ST_DEC: begin
                // Read data is registered, so it arrives in the cycle after its address.
                if (r_k != '0) begin
                    n_acc = acc_step;
                end
                if (r_k == DIGITS) begin
                    n_state = ST_OUT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_OUT: begin
                if (o_res_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wslot <= '0;
            r_k     <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_wslot <= n_wslot;
            r_k     <= n_k;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload store with registered read; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= slot_in_range && r_valid[rd_addr];
        r_acc     <= n_acc;
        r_qty     <= n_qty;
    end

endmodule

>>> rtl/ascii_record_frame_parser.sv
// Channel   Direction  Handshake          Fields
// input     in         push / full        i_rx_byte[7:0], i_response_busy
// result    out        empty / pop        o_quantity[2:0], o_value[15:0]
//
// A byte is taken while the command queue has room; bytes may arrive every cycle while it does.
// The back end stores a payload byte as it pops it; for a closing '$' on a known row it runs
// the pop, the start of the first payload read, the decode of the four digits, then the push,
// which waits while the result queue is full.
// Reset is synchronous and active low; both queues come up empty, there is no clearing pass.
// full rises only when the command queue fills; a stalled result holds on the output ports.
module ascii_record_frame_parser import arfp_pkg::*; #(
    parameter int PAYLOAD_DEPTH = 8,
    parameter int PAYLOAD_START = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_response_busy,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_quantity,
    output logic [15:0] o_value
);

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    t_cmd    front_cmd, back_cmd;
    t_result back_res, out_res;
    logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic    res_push, res_full;

    assign full       = cmd_full;
    assign o_quantity = out_res.quantity;
    assign o_value    = out_res.value;

    // Byte classifier.
    arfp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_rx_byte       (i_rx_byte),
        .i_response_busy (i_response_busy),
        .i_cmd_full      (cmd_full),
        .o_cmd_push      (cmd_push),
        .o_cmd           (front_cmd)
    );

    // Command queue between classifier and payload engine.
    arfp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // Payload store and decoder.
    arfp_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .PAYLOAD_START (PAYLOAD_START)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Result queue toward the consumer.
    arfp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

endmodule

>>> rtl/arfp_checker.sv
`include "ascii_record_frame_parser_macros.svh"

module arfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_quantity,
    input logic [15:0] o_value
);

    // After reset both queues are empty, so nothing is shown and bytes are taken.
    `ARFP_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> (empty && !full), "queues not clear after reset")

    // Only the five known quantities are ever reported.
    `ARFP_ASSERT(a_qty_range, i_clk, i_rst_n, !empty |-> (o_quantity <= 3'd4), "quantity code out of range")

    // A waiting result holds until it is taken.
    `ARFP_ASSERT(a_res_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_quantity) && $stable(o_value)), "waiting result changed")

endmodule

bind ascii_record_frame_parser arfp_checker u_arfp_checker (.*);
